FILE: hdl/htp_pkg.sv
// ----------------------------------------------------------------------------
// htp_pkg
// Shared widths, codes and constants for the heater time-proportioning PWM.
// ----------------------------------------------------------------------------
package htp_pkg;

    localparam int SLOTS = 12;

    localparam int MASK_W  = 12;
    localparam int DUTY_W  = 12;
    localparam int CHAN_W  = 4;
    localparam int COUNT_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [DUTY_W-1:0]  duty_t;
    typedef logic [COUNT_W-1:0] count_t;

    // transaction action codes
    localparam logic ACT_DUTY = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THERMO_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_CYCLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELAY_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_SSR_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELAY_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THERMO_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THERMO_ON     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE    = 3'd7;

    localparam count_t LONG_CYCLE_PERIOD = 16'd2000;
    localparam duty_t  SLOW_FULL_SCALE   = 12'd4095;
    localparam mask_t  PINS_OFF          = 12'hFFF;

endpackage

FILE: hdl/htp_if.sv
// ----------------------------------------------------------------------------
// htp_req_if / htp_rsp_if
// Valid/ready channels carrying PWM requests and the resulting heater state.
// ----------------------------------------------------------------------------
interface htp_req_if;
    import htp_pkg::*;
    logic                valid;
    logic                ready;
    logic                action;
    logic [CHAN_W-1:0]   channel;
    duty_t               duty;
    mask_t               allowed_mask;
    mask_t               step_mask;
    logic                system_halt;
    logic                burn_alarm;
    logic                adc_freeze;

    modport source (output valid, action, channel, duty, allowed_mask, step_mask,
                    system_halt, burn_alarm, adc_freeze, input ready);
    modport sink   (input valid, action, channel, duty, allowed_mask, step_mask,
                    system_halt, burn_alarm, adc_freeze, output ready);
endinterface

interface htp_rsp_if;
    import htp_pkg::*;
    logic  valid;
    logic  ready;
    mask_t heater_mask;
    mask_t pin_image;

    modport source (output valid, heater_mask, pin_image, input ready);
    modport sink   (input valid, heater_mask, pin_image, output ready);
endinterface

FILE: hdl/heater_time_proportioning_pwm.sv
// ----------------------------------------------------------------------------
// heater_time_proportioning_pwm
// Twelve-channel slow PWM for heaters with thermostat, relay and SSR modes.
// ----------------------------------------------------------------------------
// A duty write is taken in the idle state. A tick walks the min(CHANNELS,12)
// channels one per cycle, except that a channel that ends its period holds the
// walk for the on-time update, duty * period / full scale, done by one shared
// 12x16 multiplier followed by a 16-step restoring divider. The request channel
// is not ready while a tick is in progress or a result is still waiting.
module heater_time_proportioning_pwm
    import htp_pkg::*;
#(
    parameter int CHANNELS        = 12,
    parameter int FAST_SSR_PERIOD = 1250,
    parameter int SLOW_SSR_PERIOD = 10500,
    parameter int PRESCALE_TICKS  = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    htp_req_if.sink               req,
    htp_rsp_if.source             rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int NCH = (CHANNELS < SLOTS) ? CHANNELS : SLOTS;
    localparam logic [CHAN_W-1:0] NCH_W   = CHAN_W'(NCH);
    localparam count_t            FAST_P  = COUNT_W'(FAST_SSR_PERIOD);
    localparam count_t            SLOW_P  = COUNT_W'(SLOW_SSR_PERIOD);
    localparam logic [3:0]        PRE_END = 4'(PRESCALE_TICKS);
    localparam int PROD_W = DUTY_W + COUNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // configuration
    mask_t  thermo_mask_reg, relay_mask_reg, slow_mask_reg;
    logic   long_cycle_reg;
    count_t relay_period_reg, thermo_period_reg, thermo_on_reg;
    duty_t  full_scale_reg;

    // per-channel state
    duty_t      duty_reg    [SLOTS];
    count_t     count_reg   [SLOTS];
    logic [2:0] pre_reg     [SLOTS];
    count_t     on_time_reg [SLOTS];
    mask_t      heater_reg, heater_next;
    mask_t      pin_reg;

    // sequencer
    logic [2:0]        state_reg;
    logic [CHAN_W-1:0] idx_reg;
    logic [3:0]        dstep_reg;
    mask_t             allowed_reg, step_reg;
    logic              burn_reg, freeze_reg;
    logic              out_valid_reg;

    // shared multiply/divide datapath
    duty_t               mul_d_reg, fs_reg;
    count_t              mul_p_reg;
    logic [DUTY_W-1:0]   rem_reg;
    count_t              quo_reg;

    logic                accept;
    logic                out_set;
    logic                period_end;
    logic [CHAN_W-1:0]   idx;
    count_t              cnt_inc;
    logic [3:0]          pre_inc;
    logic                prescaled;
    count_t              ssr_period;
    duty_t               ssr_fs;
    logic [PROD_W-1:0]   product;
    logic [DUTY_W:0]     trial;
    logic                trial_ge;

    assign idx       = idx_reg;
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);

    assign rsp.valid       = out_valid_reg;
    assign rsp.heater_mask = heater_reg;
    assign rsp.pin_image   = pin_reg;

    assign cnt_inc   = count_reg[idx] + 16'd1;
    assign pre_inc   = {1'b0, pre_reg[idx]} + 4'd1;
    assign prescaled = long_cycle_reg || relay_mask_reg[idx];
    assign product   = mul_d_reg * mul_p_reg;
    assign trial     = {rem_reg, quo_reg[COUNT_W-1]};
    assign trial_ge  = trial >= {1'b0, fs_reg};

    // stepped SSR-style channel whose period just ran out
    assign period_end = allowed_reg[idx] && step_reg[idx] && !thermo_mask_reg[idx] &&
                        (!prescaled || pre_inc >= PRE_END) && (cnt_inc > ssr_period);

    assign out_set = (state_reg == ST_IDLE && accept &&
                      (req.action == ACT_DUTY || req.system_halt)) ||
                     (state_reg == ST_DONE);

    always_comb
    begin
        priority if (long_cycle_reg)
        begin
            ssr_period = LONG_CYCLE_PERIOD;
            ssr_fs     = full_scale_reg;
        end
        else if (relay_mask_reg[idx])
        begin
            ssr_period = relay_period_reg;
            ssr_fs     = full_scale_reg;
        end
        else if (slow_mask_reg[idx])
        begin
            ssr_period = SLOW_P;
            ssr_fs     = SLOW_FULL_SCALE;
        end
        else
        begin
            ssr_period = FAST_P;
            ssr_fs     = full_scale_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thermo_mask_reg   <= '0;
            long_cycle_reg    <= 1'b0;
            relay_mask_reg    <= '0;
            slow_mask_reg     <= '0;
            relay_period_reg  <= 16'd1000;
            thermo_period_reg <= 16'd500;
            thermo_on_reg     <= 16'd50;
            full_scale_reg    <= 12'd1000;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_THERMO_MASK:   thermo_mask_reg   <= cfg_wdata[MASK_W-1:0];
                REG_LONG_CYCLE:    long_cycle_reg    <= cfg_wdata[0];
                REG_RELAY_MASK:    relay_mask_reg    <= cfg_wdata[MASK_W-1:0];
                REG_SLOW_SSR_MASK: slow_mask_reg     <= cfg_wdata[MASK_W-1:0];
                REG_RELAY_PERIOD:  relay_period_reg  <= cfg_wdata;
                REG_THERMO_PERIOD: thermo_period_reg <= cfg_wdata;
                REG_THERMO_ON:     thermo_on_reg     <= cfg_wdata;
                REG_FULL_SCALE:    full_scale_reg    <= cfg_wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        heater_next = heater_reg;
        if (state_reg == ST_CHAN && idx_reg != NCH_W)
        begin
            if (!allowed_reg[idx])
                heater_next[idx] = 1'b0;
            else if (step_reg[idx])
            begin
                if (thermo_mask_reg[idx])
                begin
                    if (cnt_inc <= thermo_period_reg)
                        heater_next[idx] = cnt_inc <= thermo_on_reg;
                end
                else if (!prescaled || pre_inc >= PRE_END)
                begin
                    if (cnt_inc <= ssr_period)
                        heater_next[idx] = cnt_inc <= on_time_reg[idx];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            dstep_reg     <= '0;
            out_valid_reg <= 1'b0;
            heater_reg    <= '0;
            pin_reg       <= PINS_OFF;
            mul_d_reg     <= '0;
            mul_p_reg     <= '0;
            fs_reg        <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                duty_reg[i]    <= '0;
                count_reg[i]   <= '0;
                pre_reg[i]     <= '0;
                on_time_reg[i] <= '0;
            end
        end
        else
        begin
            heater_reg <= heater_next;
            if (out_set)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.action == ACT_DUTY)
                        begin
                            if (req.channel < NCH_W)
                                duty_reg[req.channel] <= req.duty;
                        end
                        else if (req.system_halt)
                            pin_reg <= PINS_OFF;
                        else
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_CHAN;
                        end
                    end
                end
                ST_CHAN:
                begin
                    if (idx_reg == NCH_W)
                        state_reg <= ST_DONE;
                    else
                    begin
                        if (!period_end)
                            idx_reg <= idx_reg + 4'd1;
                        if (allowed_reg[idx] && step_reg[idx])
                        begin
                            if (thermo_mask_reg[idx])
                                count_reg[idx] <= (cnt_inc <= thermo_period_reg)
                                                  ? cnt_inc : '0;
                            else if (prescaled && pre_inc < PRE_END)
                                pre_reg[idx] <= pre_inc[2:0];
                            else
                            begin
                                if (prescaled)
                                    pre_reg[idx] <= '0;
                                if (cnt_inc <= ssr_period)
                                    count_reg[idx] <= cnt_inc;
                                else
                                begin
                                    // period over: hold here and compute new on-time
                                    count_reg[idx] <= '0;
                                    mul_p_reg      <= ssr_period;
                                    fs_reg         <= (ssr_fs == '0) ? 12'd1 : ssr_fs;
                                    mul_d_reg      <= (duty_reg[idx] > ssr_fs &&
                                                       ssr_fs != '0) ? ssr_fs :
                                                      (ssr_fs == '0 &&
                                                       duty_reg[idx] != '0) ? 12'd1 :
                                                      duty_reg[idx];
                                    state_reg      <= ST_MUL;
                                end
                            end
                        end
                    end
                end
                ST_MUL:
                begin
                    rem_reg   <= product[PROD_W-1:COUNT_W];
                    quo_reg   <= product[COUNT_W-1:0];
                    dstep_reg <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg   <= trial_ge ? DUTY_W'(trial - {1'b0, fs_reg})
                                          : trial[DUTY_W-1:0];
                    quo_reg   <= {quo_reg[COUNT_W-2:0], trial_ge};
                    dstep_reg <= dstep_reg + 4'd1;
                    if (dstep_reg == 4'd15)
                    begin
                        on_time_reg[idx] <= {quo_reg[COUNT_W-2:0], trial_ge};
                        idx_reg          <= idx_reg + 4'd1;
                        state_reg        <= ST_CHAN;
                    end
                end
                ST_DONE:
                begin
                    if (!freeze_reg)
                        pin_reg <= burn_reg ? PINS_OFF : ~heater_reg;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            allowed_reg <= req.allowed_mask;
            step_reg    <= req.step_mask;
            burn_reg    <= req.burn_alarm;
            freeze_reg  <= req.adc_freeze;
        end
    end

    // a busy sequencer never takes a new transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !req.ready)
        else $error("request accepted while busy");

    // halt tick reports pins off on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.action == ACT_TICK && req.system_halt
        |=> rsp.valid && rsp.pin_image == PINS_OFF)
        else $error("halt did not force pins off");

    // channel walk stays within the channel count
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= NCH_W)
        else $error("channel index out of range");

    // divider only runs on a channel that exists
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> idx_reg < NCH_W && fs_reg != '0)
        else $error("divider started with bad operands");

endmodule
